FILE: rtl/core/ipcsp_pkg.sv
// ----------------------------------------------------------------------------
// ipcsp_pkg: shared definitions of the classifying stride prefetcher
// Field widths, class and direction codes, thresholds, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ipcsp_pkg;

    // Default table geometry.
    localparam int IP_SETS_DFLT   = 64;
    localparam int IP_WAYS_DFLT   = 4;
    localparam int SIG_SETS_DFLT  = 128;
    localparam int SIG_WAYS_DFLT  = 4;
    localparam int PAGE_BITS_DFLT = 6;

    // Field widths.
    localparam int IP_W    = 48;
    localparam int BLK_W   = 58;
    localparam int STR_W   = 59;
    localparam int SIG_W   = 12;
    localparam int CONF_W  = 4;
    localparam int CLS_W   = 2;
    localparam int META_W  = 32;
    localparam int CNT_W   = 11;
    localparam int DEG_W   = 4;
    localparam int MKEY_W  = 48;
    localparam int MSTEP_W = 3;

    // Load classes.
    localparam logic [CLS_W-1:0] CL_NL   = 2'd0;
    localparam logic [CLS_W-1:0] CL_CS   = 2'd1;
    localparam logic [CLS_W-1:0] CL_CPLX = 2'd2;
    localparam logic [CLS_W-1:0] CL_GS   = 2'd3;

    // Global stream direction.
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    // Confidence thresholds.
    localparam logic [CONF_W-1:0] CONF_MAX       = 4'd8;
    localparam logic [CONF_W-1:0] CONF_HIGH      = 4'd4;
    localparam logic [CONF_W-1:0] CONF_CPLX_MIN  = 4'd2;
    localparam logic [CONF_W-1:0] CONF_CPLX_KEEP = 4'd1;

    localparam logic [STR_W-1:0] GS_MAX_MAG  = 59'd64;
    localparam logic [CNT_W:0]   DIR_MARGIN  = 12'd3;
    localparam logic [CNT_W:0]   DECAY_LIMIT = 12'd1024;

    // Prefetch degree for each class.
    localparam logic [DEG_W-1:0] DEG_CS   = 4'd8;
    localparam logic [DEG_W-1:0] DEG_CPLX = 4'd3;
    localparam logic [DEG_W-1:0] DEG_GS   = 4'd5;
    localparam logic [DEG_W-1:0] DEG_NL   = 4'd1;
    localparam logic [DEG_W-1:0] DEG_NONE = 4'd0;

    // Set index reduction runs one byte per step.
    localparam logic [MSTEP_W-1:0] IP_MOD_STEPS  = 3'd6;
    localparam logic [MSTEP_W-1:0] SIG_MOD_STEPS = 3'd2;

    typedef struct packed {
        logic clear;
        logic accept;
        logic ip_rd;
        logic ip_eval;
        logic ip_upd;
        logic mod_sig_old;
        logic mod_sig_new;
        logic sig_rd;
        logic sig1_wr;
        logic sig2_eval;
        logic gen_setup;
        logic gen_run;
        logic gen_flush;
    } ipcsp_cmd_t;

    typedef struct packed {
        logic             clear_last;
        logic             mod_done;
        logic [CLS_W-1:0] cls;
        logic             gen_done;
        logic             flush_done;
        logic             pend_valid;
    } ipcsp_sts_t;

endpackage

FILE: rtl/core/ipcsp_if.sv
// ----------------------------------------------------------------------------
// ipcsp_if: channel interfaces of the classifying stride prefetcher
// The access channel carries one cache access per item, the prefetch
// channel carries one prefetch request per item.
// ----------------------------------------------------------------------------
interface ipcsp_req_if import ipcsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [IP_W-1:0]   instr_addr;
    logic [BLK_W-1:0]  block_addr;
    logic              mshr_fill_ok;
    logic [META_W-1:0] meta_in;

    modport source (output valid, output instr_addr, output block_addr,
                    output mshr_fill_ok, output meta_in, input ready);
    modport sink   (input valid, input instr_addr, input block_addr,
                    input mshr_fill_ok, input meta_in, output ready);
endinterface

interface ipcsp_pf_if import ipcsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BLK_W-1:0]  prefetch_block;
    logic              fill_here;
    logic [META_W-1:0] meta_out;
    logic              last_request;

    modport source (output valid, output prefetch_block, output fill_here,
                    output meta_out, output last_request, input ready);
    modport sink   (input valid, input prefetch_block, input fill_here,
                    input meta_out, input last_request, output ready);
endinterface

FILE: rtl/core/ipcsp_ctrl.sv
// ----------------------------------------------------------------------------
// ipcsp_ctrl: sequencer of the classifying stride prefetcher
// Steps one access through set reduction, table read, update, signature
// table work and prefetch generation.
// ----------------------------------------------------------------------------
module ipcsp_ctrl import ipcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output ipcsp_cmd_t cmd,
    input  ipcsp_sts_t sts
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_IP_MOD    = 4'd2;
    localparam logic [3:0] S_IP_RD     = 4'd3;
    localparam logic [3:0] S_IP_EVAL   = 4'd4;
    localparam logic [3:0] S_IP_UPD    = 4'd5;
    localparam logic [3:0] S_DISPATCH  = 4'd6;
    localparam logic [3:0] S_SIG1_MOD  = 4'd7;
    localparam logic [3:0] S_SIG1_RD   = 4'd8;
    localparam logic [3:0] S_SIG1_WR   = 4'd9;
    localparam logic [3:0] S_SIG2_MOD  = 4'd10;
    localparam logic [3:0] S_SIG2_RD   = 4'd11;
    localparam logic [3:0] S_SIG2_EVAL = 4'd12;
    localparam logic [3:0] S_GEN_SETUP = 4'd13;
    localparam logic [3:0] S_GEN_RUN   = 4'd14;
    localparam logic [3:0] S_GEN_FLUSH = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_IP_MOD;
                end
            end
            S_IP_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_IP_RD;
                end
            end
            S_IP_RD:
            begin
                cmd.ip_rd  = 1'b1;
                state_next = S_IP_EVAL;
            end
            S_IP_EVAL:
            begin
                cmd.ip_eval = 1'b1;
                state_next  = S_IP_UPD;
            end
            S_IP_UPD:
            begin
                cmd.ip_upd = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (sts.cls == CL_CPLX)
                begin
                    cmd.mod_sig_old = 1'b1;
                    state_next      = S_SIG1_MOD;
                end
                else
                begin
                    state_next = S_GEN_SETUP;
                end
            end
            S_SIG1_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_SIG1_RD;
                end
            end
            S_SIG1_RD:
            begin
                cmd.sig_rd = 1'b1;
                state_next = S_SIG1_WR;
            end
            S_SIG1_WR:
            begin
                cmd.sig1_wr     = 1'b1;
                cmd.mod_sig_new = 1'b1;
                state_next      = S_SIG2_MOD;
            end
            S_SIG2_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_SIG2_RD;
                end
            end
            S_SIG2_RD:
            begin
                cmd.sig_rd = 1'b1;
                state_next = S_SIG2_EVAL;
            end
            S_SIG2_EVAL:
            begin
                cmd.sig2_eval = 1'b1;
                state_next    = S_GEN_SETUP;
            end
            S_GEN_SETUP:
            begin
                cmd.gen_setup = 1'b1;
                state_next    = S_GEN_RUN;
            end
            S_GEN_RUN:
            begin
                cmd.gen_run = 1'b1;
                if (sts.gen_done)
                begin
                    state_next = S_GEN_FLUSH;
                end
            end
            S_GEN_FLUSH:
            begin
                cmd.gen_flush = 1'b1;
                if (sts.flush_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/ipcsp_dp.sv
// ----------------------------------------------------------------------------
// ipcsp_dp: datapath of the classifying stride prefetcher
// Holds the IP and signature tables, the set reduction unit, the global
// stream counters and the prefetch generator with its output register.
// ----------------------------------------------------------------------------
module ipcsp_dp import ipcsp_pkg::*;
#(
    parameter int IP_SETS   = IP_SETS_DFLT,
    parameter int IP_WAYS   = IP_WAYS_DFLT,
    parameter int SIG_SETS  = SIG_SETS_DFLT,
    parameter int SIG_WAYS  = SIG_WAYS_DFLT,
    parameter int PAGE_BITS = PAGE_BITS_DFLT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ipcsp_cmd_t        cmd,
    output ipcsp_sts_t        sts,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic [IP_W-1:0]   instr_addr,
    input  logic [BLK_W-1:0]  block_addr,
    input  logic              mshr_fill_ok,
    input  logic [META_W-1:0] meta_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BLK_W-1:0]  prefetch_block,
    output logic              fill_here,
    output logic [META_W-1:0] meta_out,
    output logic              last_request
);

    localparam int IP_IDX_W  = (IP_SETS > 1) ? $clog2(IP_SETS) : 1;
    localparam int SIG_IDX_W = (SIG_SETS > 1) ? $clog2(SIG_SETS) : 1;
    localparam int IP_AGE_W  = (IP_WAYS > 1) ? $clog2(IP_WAYS) : 1;
    localparam int SIG_AGE_W = (SIG_WAYS > 1) ? $clog2(SIG_WAYS) : 1;
    localparam int MAX_SETS  = (IP_SETS > SIG_SETS) ? IP_SETS : SIG_SETS;
    localparam int MOD_W     = $clog2(MAX_SETS + 1);
    localparam int V_W       = MOD_W + 8;
    localparam int CLR_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int CLRC_W    = CLR_W + 1;

    typedef struct packed {
        logic                    valid;
        logic [IP_W-1:0]         tag;
        logic [BLK_W-1:0]        prev_block;
        logic signed [STR_W-1:0] stride;
        logic [CONF_W-1:0]       conf;
        logic [CLS_W-1:0]        cls;
        logic [SIG_W-1:0]        sig;
        logic [IP_AGE_W-1:0]     age;
    } ip_ent_t;
    typedef ip_ent_t [IP_WAYS-1:0] ip_row_t;

    typedef struct packed {
        logic                    valid;
        logic [SIG_W-1:0]        tag;
        logic signed [STR_W-1:0] delta;
        logic [SIG_AGE_W-1:0]    age;
    } sig_ent_t;
    typedef sig_ent_t [SIG_WAYS-1:0] sig_row_t;

    // ------------------------------------------------------------------
    // Helper functions.
    // ------------------------------------------------------------------
    function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
                                                  input logic [7:0] octet,
                                                  input logic [MOD_W-1:0] m);
        logic [V_W-1:0] v;
        logic [V_W-1:0] s;
        v = {rem, octet};
        for (int k = 7; k >= 0; k--)
        begin
            s = V_W'(m) << k;
            if (v >= s)
            begin
                v = v - s;
            end
        end
        return v[MOD_W-1:0];
    endfunction

    function automatic ip_row_t ip_touch(input ip_row_t r, input logic [IP_AGE_W-1:0] w);
        ip_row_t o;
        o = r;
        for (int i = 0; i < IP_WAYS; i++)
        begin
            if (IP_AGE_W'(i) == w)
            begin
                o[i].age = '0;
            end
            else if (r[i].age < r[w].age)
            begin
                o[i].age = r[i].age + 1'b1;
            end
        end
        return o;
    endfunction

    function automatic logic [IP_AGE_W-1:0] ip_victim(input ip_row_t r);
        logic                found;
        logic [IP_AGE_W-1:0] v;
        found = 1'b0;
        v     = '0;
        for (int i = 0; i < IP_WAYS; i++)
        begin
            if (!found && !r[i].valid)
            begin
                found = 1'b1;
                v     = IP_AGE_W'(i);
            end
        end
        if (!found)
        begin
            for (int i = 1; i < IP_WAYS; i++)
            begin
                if (r[i].age > r[v].age)
                begin
                    v = IP_AGE_W'(i);
                end
            end
        end
        return v;
    endfunction

    function automatic sig_row_t sig_touch(input sig_row_t r, input logic [SIG_AGE_W-1:0] w);
        sig_row_t o;
        o = r;
        for (int i = 0; i < SIG_WAYS; i++)
        begin
            if (SIG_AGE_W'(i) == w)
            begin
                o[i].age = '0;
            end
            else if (r[i].age < r[w].age)
            begin
                o[i].age = r[i].age + 1'b1;
            end
        end
        return o;
    endfunction

    function automatic logic [SIG_AGE_W-1:0] sig_victim(input sig_row_t r);
        logic                 found;
        logic [SIG_AGE_W-1:0] v;
        found = 1'b0;
        v     = '0;
        for (int i = 0; i < SIG_WAYS; i++)
        begin
            if (!found && !r[i].valid)
            begin
                found = 1'b1;
                v     = SIG_AGE_W'(i);
            end
        end
        if (!found)
        begin
            for (int i = 1; i < SIG_WAYS; i++)
            begin
                if (r[i].age > r[v].age)
                begin
                    v = SIG_AGE_W'(i);
                end
            end
        end
        return v;
    endfunction

    function automatic logic [CLS_W-1:0] classify(input logic signed [STR_W-1:0] old_s,
                                                  input logic signed [STR_W-1:0] new_s,
                                                  input logic [CONF_W-1:0] conf,
                                                  input logic [CLS_W-1:0] old_cls,
                                                  input logic [1:0] dir);
        logic [STR_W-1:0] mag;
        logic             match;
        mag   = new_s[STR_W-1] ? STR_W'(-new_s) : new_s;
        match = (dir == DIR_UP && !new_s[STR_W-1]) || (dir == DIR_DOWN && new_s[STR_W-1]);
        if (new_s == '0)
        begin
            return CL_NL;
        end
        if (match && mag <= GS_MAX_MAG && (conf < CONF_HIGH || old_cls == CL_GS))
        begin
            return CL_GS;
        end
        if (new_s == old_s)
        begin
            return (conf >= CONF_HIGH || old_cls == CL_CS) ? CL_CS : CL_NL;
        end
        if (old_cls == CL_CPLX && conf >= CONF_CPLX_KEEP)
        begin
            return CL_CPLX;
        end
        if (conf >= CONF_CPLX_MIN)
        begin
            return CL_CPLX;
        end
        return CL_NL;
    endfunction

    // ------------------------------------------------------------------
    // Captured access and configuration.
    // ------------------------------------------------------------------
    logic              vp_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic              fill_reg;
    logic [META_W-1:0] meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            vp_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ip_reg   <= instr_addr;
            blk_reg  <= block_addr;
            fill_reg <= mshr_fill_ok;
            meta_reg <= meta_in;
        end
    end

    // ------------------------------------------------------------------
    // Set reduction: key modulo the set count, one byte per cycle.
    // ------------------------------------------------------------------
    logic [MKEY_W-1:0]  mkey_reg;
    logic [MSTEP_W-1:0] mcnt_reg;
    logic [MOD_W-1:0]   rem_reg;
    logic               msig_reg;
    logic [MOD_W-1:0]   modulus;
    logic [SIG_W-1:0]   old_sig_reg;
    logic [SIG_W-1:0]   sig_reg;

    assign modulus = msig_reg ? MOD_W'(SIG_SETS) : MOD_W'(IP_SETS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
            rem_reg  <= '0;
            msig_reg <= 1'b0;
            mkey_reg <= '0;
        end
        else if (cmd.accept)
        begin
            mcnt_reg <= IP_MOD_STEPS;
            rem_reg  <= '0;
            msig_reg <= 1'b0;
            mkey_reg <= instr_addr;
        end
        else if (cmd.mod_sig_old || cmd.mod_sig_new)
        begin
            mcnt_reg <= SIG_MOD_STEPS;
            rem_reg  <= '0;
            msig_reg <= 1'b1;
            mkey_reg <= {4'b0000, (cmd.mod_sig_old ? old_sig_reg : sig_reg), 32'd0};
        end
        else if (mcnt_reg != '0)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
            rem_reg  <= mod_step(rem_reg, mkey_reg[MKEY_W-1 -: 8], modulus);
            mkey_reg <= mkey_reg << 8;
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep after reset.
    // ------------------------------------------------------------------
    logic [CLR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // IP table.
    // ------------------------------------------------------------------
    ip_row_t                 ip_mem [IP_SETS];
    ip_row_t                 ip_rdata_reg;
    ip_row_t                 ip_wdata;
    ip_row_t                 ip_clr_row;
    ip_row_t                 ip_upd_row;
    logic                    ip_we;
    logic [IP_IDX_W-1:0]     ip_set;
    logic [IP_IDX_W-1:0]     ip_waddr;

    logic                    hit_c;
    logic [IP_AGE_W-1:0]     hw_c;
    ip_ent_t                 ent_c;
    logic                    hit_reg;
    logic [IP_AGE_W-1:0]     way_reg;
    logic signed [STR_W-1:0] new_s_reg;
    logic signed [STR_W-1:0] old_s_reg;
    logic [CONF_W-1:0]       old_conf_reg;
    logic [CLS_W-1:0]        old_cls_reg;

    assign ip_set   = rem_reg[IP_IDX_W-1:0];
    assign ip_waddr = cmd.clear ? clr_cnt_reg[IP_IDX_W-1:0] : ip_set;
    assign ip_we    = (cmd.clear && ({1'b0, clr_cnt_reg} < CLRC_W'(IP_SETS))) || cmd.ip_upd;
    assign ip_wdata = cmd.clear ? ip_clr_row : ip_upd_row;

    always_comb
    begin
        for (int i = 0; i < IP_WAYS; i++)
        begin
            ip_clr_row[i]     = '0;
            ip_clr_row[i].age = IP_AGE_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            ip_mem[ip_waddr] <= ip_wdata;
        end
        if (cmd.ip_rd)
        begin
            ip_rdata_reg <= ip_mem[ip_set];
        end
    end

    // Tag match over the read row.
    always_comb
    begin
        hit_c = 1'b0;
        hw_c  = '0;
        for (int i = 0; i < IP_WAYS; i++)
        begin
            if (!hit_c && ip_rdata_reg[i].valid && ip_rdata_reg[i].tag == ip_reg)
            begin
                hit_c = 1'b1;
                hw_c  = IP_AGE_W'(i);
            end
        end
        ent_c = ip_rdata_reg[hw_c];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ip_eval)
        begin
            hit_reg      <= hit_c;
            way_reg      <= hit_c ? hw_c : ip_victim(ip_rdata_reg);
            new_s_reg    <= hit_c ? ({1'b0, blk_reg} - {1'b0, ent_c.prev_block}) : '0;
            old_s_reg    <= ent_c.stride;
            old_conf_reg <= ent_c.conf;
            old_cls_reg  <= ent_c.cls;
            old_sig_reg  <= hit_c ? ent_c.sig : '0;
        end
    end

    // Entry update, classification and global stream counters.
    logic [CONF_W-1:0]      conf_u;
    logic [CLS_W-1:0]       cls_u;
    logic [SIG_W-1:0]       sig_u;
    logic [4:0]             sig_bits;
    logic [SIG_W+2:0]       sig_shift;
    logic [STR_W-1:0]       mag_u;
    logic                   s_eq;
    logic                   s_nz;
    logic [CNT_W-1:0]       up_reg;
    logic [CNT_W-1:0]       down_reg;
    logic [1:0]             dir_reg;
    logic [CLS_W-1:0]       cls_reg;
    logic [CNT_W-1:0]       up_inc;
    logic [CNT_W-1:0]       down_inc;
    logic [CNT_W:0]         sum_c;
    logic signed [CNT_W:0]  diff_c;
    logic [1:0]             dir_u;
    ip_ent_t                new_ent;

    always_comb
    begin
        s_eq = (new_s_reg == old_s_reg);
        s_nz = (new_s_reg != '0);

        conf_u = old_conf_reg;
        if (!hit_reg)
        begin
            conf_u = '0;
        end
        else if (s_eq && s_nz)
        begin
            if (old_conf_reg < CONF_MAX)
            begin
                conf_u = old_conf_reg + 1'b1;
            end
        end
        else if (!s_eq)
        begin
            if (old_conf_reg != '0)
            begin
                conf_u = old_conf_reg - 1'b1;
            end
        end

        cls_u = hit_reg ? classify(old_s_reg, new_s_reg, conf_u, old_cls_reg, dir_reg) : CL_NL;

        mag_u     = new_s_reg[STR_W-1] ? STR_W'(-new_s_reg) : new_s_reg;
        sig_bits  = {new_s_reg[STR_W-1], mag_u[3:0]};
        sig_shift = {old_sig_reg, 3'b000} ^ {10'd0, sig_bits};
        sig_u     = (hit_reg && s_nz) ? sig_shift[SIG_W-1:0] : old_sig_reg;

        up_inc   = (s_nz && !new_s_reg[STR_W-1]) ? up_reg + 1'b1 : up_reg;
        down_inc = (new_s_reg[STR_W-1]) ? down_reg + 1'b1 : down_reg;
        diff_c   = $signed({1'b0, up_inc}) - $signed({1'b0, down_inc});
        sum_c    = {1'b0, up_inc} + {1'b0, down_inc};
        dir_u    = dir_reg;
        if (diff_c > $signed(DIR_MARGIN))
        begin
            dir_u = DIR_UP;
        end
        else if (-diff_c > $signed(DIR_MARGIN))
        begin
            dir_u = DIR_DOWN;
        end

        new_ent            = '0;
        new_ent.valid      = 1'b1;
        new_ent.tag        = ip_reg;
        new_ent.prev_block = blk_reg;
        new_ent.stride     = new_s_reg;
        new_ent.conf       = conf_u;
        new_ent.cls        = cls_u;
        new_ent.sig        = sig_u;
        new_ent.age        = ip_rdata_reg[way_reg].age;
        ip_upd_row           = ip_rdata_reg;
        ip_upd_row[way_reg]  = new_ent;
        ip_upd_row           = ip_touch(ip_upd_row, way_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= '0;
            down_reg <= '0;
            dir_reg  <= DIR_NONE;
            cls_reg  <= CL_NL;
        end
        else if (cmd.ip_upd)
        begin
            cls_reg <= cls_u;
            dir_reg <= dir_u;
            if (sum_c > DECAY_LIMIT)
            begin
                up_reg   <= up_inc >> 1;
                down_reg <= down_inc >> 1;
            end
            else
            begin
                up_reg   <= up_inc;
                down_reg <= down_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ip_upd)
        begin
            sig_reg <= sig_u;
        end
    end

    // ------------------------------------------------------------------
    // Signature table.
    // ------------------------------------------------------------------
    sig_row_t                sig_mem [SIG_SETS];
    sig_row_t                sig_rdata_reg;
    sig_row_t                sig_wdata;
    sig_row_t                sig_clr_row;
    sig_row_t                sig1_row;
    sig_row_t                sig2_row;
    logic                    sig_we;
    logic [SIG_IDX_W-1:0]    sig_set;
    logic [SIG_IDX_W-1:0]    sig_waddr;
    logic                    m1_hit;
    logic [SIG_AGE_W-1:0]    m1_way;
    logic [SIG_AGE_W-1:0]    w1_way;
    logic                    m2_hit;
    logic [SIG_AGE_W-1:0]    m2_way;
    sig_ent_t                sig1_ent;
    logic                    sig_hit_reg;
    logic signed [STR_W-1:0] sig_delta_reg;

    assign sig_set   = rem_reg[SIG_IDX_W-1:0];
    assign sig_waddr = cmd.clear ? clr_cnt_reg[SIG_IDX_W-1:0] : sig_set;
    assign sig_we    = (cmd.clear && ({1'b0, clr_cnt_reg} < CLRC_W'(SIG_SETS)))
                       || cmd.sig1_wr || (cmd.sig2_eval && m2_hit);
    assign sig_wdata = cmd.clear ? sig_clr_row : (cmd.sig1_wr ? sig1_row : sig2_row);

    always_comb
    begin
        for (int i = 0; i < SIG_WAYS; i++)
        begin
            sig_clr_row[i]     = '0;
            sig_clr_row[i].age = SIG_AGE_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sig_we)
        begin
            sig_mem[sig_waddr] <= sig_wdata;
        end
        if (cmd.sig_rd)
        begin
            sig_rdata_reg <= sig_mem[sig_set];
        end
    end

    always_comb
    begin
        m1_hit = 1'b0;
        m1_way = '0;
        m2_hit = 1'b0;
        m2_way = '0;
        for (int i = 0; i < SIG_WAYS; i++)
        begin
            if (!m1_hit && sig_rdata_reg[i].valid && sig_rdata_reg[i].tag == old_sig_reg)
            begin
                m1_hit = 1'b1;
                m1_way = SIG_AGE_W'(i);
            end
            if (!m2_hit && sig_rdata_reg[i].valid && sig_rdata_reg[i].tag == sig_reg)
            begin
                m2_hit = 1'b1;
                m2_way = SIG_AGE_W'(i);
            end
        end
        w1_way         = m1_hit ? m1_way : sig_victim(sig_rdata_reg);
        sig1_ent       = sig_rdata_reg[w1_way];
        sig1_ent.valid = 1'b1;
        sig1_ent.tag   = old_sig_reg;
        sig1_ent.delta = new_s_reg;
        sig1_row          = sig_rdata_reg;
        sig1_row[w1_way]  = sig1_ent;
        sig1_row          = sig_touch(sig1_row, w1_way);
        sig2_row          = sig_touch(sig_rdata_reg, m2_way);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_hit_reg <= 1'b0;
        end
        else if (cmd.sig2_eval)
        begin
            sig_hit_reg <= m2_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sig2_eval)
        begin
            sig_delta_reg <= sig_rdata_reg[m2_way].delta;
        end
    end

    // ------------------------------------------------------------------
    // Prefetch generator. Candidates are made by repeated addition of the
    // delta; one passing candidate is held back so that the last one can
    // be marked when the sweep ends.
    // ------------------------------------------------------------------
    logic [DEG_W-1:0]        degree_reg;
    logic [DEG_W-1:0]        gen_cnt_reg;
    logic signed [STR_W-1:0] delta_reg;
    logic [BLK_W-1:0]        gen_acc_reg;
    logic                    pend_valid_reg;
    logic [BLK_W-1:0]        pend_pf_reg;
    logic                    out_valid_reg;
    logic [BLK_W-1:0]        out_pf_reg;
    logic                    out_fill_reg;
    logic [META_W-1:0]       out_meta_reg;
    logic                    out_last_reg;
    logic [BLK_W-1:0]        cand;
    logic                    cand_pass;
    logic                    gen_done;
    logic                    out_free;
    logic                    step_ok;
    logic                    out_load;
    logic                    out_load_last;
    logic [DEG_W-1:0]        degree_c;
    logic signed [STR_W-1:0] delta_c;

    assign gen_done  = (gen_cnt_reg == degree_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign cand      = gen_acc_reg + delta_reg[BLK_W-1:0];
    assign cand_pass = vp_reg || (cand[BLK_W-1:PAGE_BITS] == blk_reg[BLK_W-1:PAGE_BITS]);
    assign step_ok   = cmd.gen_run && !gen_done && (!(cand_pass && pend_valid_reg) || out_free);
    assign out_load_last = cmd.gen_flush && pend_valid_reg && out_free;
    assign out_load  = (step_ok && cand_pass && pend_valid_reg) || out_load_last;

    always_comb
    begin
        case (cls_reg)
            CL_CS:
            begin
                degree_c = DEG_CS;
                delta_c  = new_s_reg;
            end
            CL_GS:
            begin
                degree_c = DEG_GS;
                delta_c  = (dir_reg == DIR_DOWN) ? -STR_W'(1) : STR_W'(1);
            end
            CL_CPLX:
            begin
                degree_c = (sig_hit_reg && sig_delta_reg != '0) ? DEG_CPLX : DEG_NONE;
                delta_c  = sig_delta_reg;
            end
            default:
            begin
                degree_c = DEG_NL;
                delta_c  = STR_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg     <= '0;
            gen_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.gen_setup)
            begin
                degree_reg  <= degree_c;
                gen_cnt_reg <= '0;
            end
            else if (step_ok)
            begin
                gen_cnt_reg <= gen_cnt_reg + 1'b1;
            end

            if (step_ok && cand_pass)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_load_last)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_setup)
        begin
            delta_reg   <= delta_c;
            gen_acc_reg <= blk_reg;
        end
        else if (step_ok)
        begin
            gen_acc_reg <= cand;
        end
        if (step_ok && cand_pass)
        begin
            pend_pf_reg <= cand;
        end
        if (out_load)
        begin
            out_pf_reg   <= pend_pf_reg;
            out_fill_reg <= fill_reg;
            out_meta_reg <= meta_reg;
            out_last_reg <= out_load_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign prefetch_block = out_pf_reg;
    assign fill_here      = out_fill_reg;
    assign meta_out       = out_meta_reg;
    assign last_request   = out_last_reg;

    assign sts.clear_last = (clr_cnt_reg == CLR_W'(MAX_SETS - 1));
    assign sts.mod_done   = (mcnt_reg == '0);
    assign sts.cls        = cls_reg;
    assign sts.gen_done   = gen_done;
    assign sts.flush_done = !pend_valid_reg || out_free;
    assign sts.pend_valid = pend_valid_reg;

endmodule

FILE: rtl/core/ip_classifying_stride_prefetcher.sv
// ----------------------------------------------------------------------------
// ip_classifying_stride_prefetcher: classifying stride prefetcher, top level
// Joins the sequencer and the datapath and carries the access channel, the
// prefetch channel and the configuration register.
// ----------------------------------------------------------------------------
// Each item on the access channel is one cache access; it yields zero to
// eight prefetch items, the final one flagged by last_request. The block
// handles one access at a time. An access passes through the accept, the
// byte-wise set reduction of the instruction address with its done check,
// one IP table read, one evaluation and one write, and dispatch; complex
// loads then walk the signature table twice through its single port before
// generator setup. The generator then steps through each of the up to
// eight candidate blocks, sees the end of the candidate sweep and releases
// the final request; a stalled prefetch channel stretches the candidate
// and release phases. The prefetch output register lets the next access be
// taken while the final request still waits. After reset the block sweeps
// both tables once, one set per cycle, before it takes the first access;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module ip_classifying_stride_prefetcher import ipcsp_pkg::*;
#(
    parameter int IP_TABLE_SETS   = IP_SETS_DFLT,
    parameter int IP_TABLE_WAYS   = IP_WAYS_DFLT,
    parameter int SIG_TABLE_SETS  = SIG_SETS_DFLT,
    parameter int SIG_TABLE_WAYS  = SIG_WAYS_DFLT,
    parameter int PAGE_BLOCK_BITS = PAGE_BITS_DFLT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    ipcsp_req_if.sink   req,
    ipcsp_pf_if.source  pf
);

    // Command and status between the sequencer and the datapath.
    ipcsp_cmd_t cmd;
    ipcsp_sts_t sts;

    ipcsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath owns both tables, the stream counters and the output
    // register that drives the prefetch channel.
    ipcsp_dp #(
        .IP_SETS   (IP_TABLE_SETS),
        .IP_WAYS   (IP_TABLE_WAYS),
        .SIG_SETS  (SIG_TABLE_SETS),
        .SIG_WAYS  (SIG_TABLE_WAYS),
        .PAGE_BITS (PAGE_BLOCK_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .instr_addr     (req.instr_addr),
        .block_addr     (req.block_addr),
        .mshr_fill_ok   (req.mshr_fill_ok),
        .meta_in        (req.meta_in),
        .out_valid      (pf.valid),
        .out_ready      (pf.ready),
        .prefetch_block (pf.prefetch_block),
        .fill_here      (pf.fill_here),
        .meta_out       (pf.meta_out),
        .last_request   (pf.last_request)
    );

`ifndef SYNTHESIS
    // No access is taken while the tables are being swept.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !req.ready)
        else $error("access accepted during table sweep");

    // An accepted access keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("access channel ready right after an accept");

    // A held-back request never survives into the next access.
    a_pend_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        sts.pend_valid |-> !req.ready)
        else $error("access accepted with a prefetch still pending");

    // The generator starts with nothing held back.
    a_setup_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gen_setup |-> !sts.pend_valid)
        else $error("generator setup with a pending request");
`endif

endmodule

FILE: tb/sv/tb_ip_classifying_stride_prefetcher.sv
// ----------------------------------------------------------------------------
// tb_ip_classifying_stride_prefetcher: self-checking bench of the prefetcher
// Drives cache accesses, predicts the prefetch requests of each access from
// a behavioral copy of the tables and counters, and compares every request
// field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ip_classifying_stride_prefetcher;
    import ipcsp_pkg::*;

    localparam int IPS   = IP_SETS_DFLT;
    localparam int IPW   = IP_WAYS_DFLT;
    localparam int SGS   = SIG_SETS_DFLT;
    localparam int SGW   = SIG_WAYS_DFLT;
    localparam int PGB   = PAGE_BITS_DFLT;
    localparam int LIMIT = 400000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [IP_W-1:0]   instr_addr;
        logic [BLK_W-1:0]  block_addr;
        logic              mshr_fill_ok;
        logic [META_W-1:0] meta_in;
    } access_t;

    typedef struct packed {
        logic [BLK_W-1:0]  prefetch_block;
        logic              fill_here;
        logic [META_W-1:0] meta_out;
        logic              last_request;
    } pf_req_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    ipcsp_req_if req ();
    ipcsp_pf_if  pf ();

    ip_classifying_stride_prefetcher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .pf          (pf)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the block's state, kept in the predictor's own terms.
    bit                       vpf;
    bit                       ipt_valid [IPS*IPW];
    logic [IP_W-1:0]          ipt_tag   [IPS*IPW];
    logic [BLK_W-1:0]         ipt_blk   [IPS*IPW];
    logic signed [STR_W-1:0]  ipt_str   [IPS*IPW];
    int                       ipt_conf  [IPS*IPW];
    logic [CLS_W-1:0]         ipt_cls   [IPS*IPW];
    logic [SIG_W-1:0]         ipt_sig   [IPS*IPW];
    int                       ipt_age   [IPS*IPW];
    bit                       sgt_valid [SGS*SGW];
    logic [SIG_W-1:0]         sgt_tag   [SGS*SGW];
    logic signed [STR_W-1:0]  sgt_delta [SGS*SGW];
    int                       sgt_age   [SGS*SGW];
    int                       up_cnt;
    int                       down_cnt;
    int                       stream_dir;

    pf_req_t expected_pf[$];
    access_t pending_access[$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  hold_sender;
    int  mismatches;
    int  cycle_count;

    task automatic clear_shadow();
        vpf = 0;
        for (int i = 0; i < IPS*IPW; i++)
        begin
            ipt_valid[i] = 0;
            ipt_age[i] = i % IPW;
        end
        for (int i = 0; i < SGS*SGW; i++)
        begin
            sgt_valid[i] = 0;
            sgt_age[i] = i % SGW;
        end
        up_cnt = 0;
        down_cnt = 0;
        stream_dir = 0;
    endtask

    function automatic void touch_ip(int base, int w);
        int rank;
        rank = ipt_age[base + w];
        for (int i = 0; i < IPW; i++)
            if (ipt_age[base + i] < rank)
                ipt_age[base + i]++;
        ipt_age[base + w] = 0;
    endfunction

    function automatic void touch_sig(int base, int w);
        int rank;
        rank = sgt_age[base + w];
        for (int i = 0; i < SGW; i++)
            if (sgt_age[base + i] < rank)
                sgt_age[base + i]++;
        sgt_age[base + w] = 0;
    endfunction

    function automatic int ip_victim(int base);
        int best;
        best = 0;
        for (int i = 0; i < IPW; i++)
            if (!ipt_valid[base + i])
                return i;
        for (int i = 1; i < IPW; i++)
            if (ipt_age[base + i] > ipt_age[base + best])
                best = i;
        return best;
    endfunction

    function automatic int sig_victim(int base);
        int best;
        best = 0;
        for (int i = 0; i < SGW; i++)
            if (!sgt_valid[base + i])
                return i;
        for (int i = 1; i < SGW; i++)
            if (sgt_age[base + i] > sgt_age[base + best])
                best = i;
        return best;
    endfunction

    function automatic logic [CLS_W-1:0] class_of(logic signed [STR_W-1:0] old_s,
                                                  logic signed [STR_W-1:0] new_s,
                                                  int conf, logic [CLS_W-1:0] old_cls);
        logic signed [STR_W-1:0] mag;
        bit                      same_dir;
        mag = (new_s < 0) ? -new_s : new_s;
        if (new_s == 0)
            return CL_NL;
        same_dir = (stream_dir > 0 && new_s > 0) || (stream_dir < 0 && new_s < 0);
        if (stream_dir != 0 && same_dir && mag <= 64 && (conf < 4 || old_cls == CL_GS))
            return CL_GS;
        if (new_s == old_s)
            return (conf >= 4 || old_cls == CL_CS) ? CL_CS : CL_NL;
        if (old_cls == CL_CPLX && conf >= 1)
            return CL_CPLX;
        if (conf >= 2)
            return CL_CPLX;
        return CL_NL;
    endfunction

    // Queue the requests for delta*1..delta*degree that stay on the page,
    // unless page crossing is allowed.
    function automatic void queue_prefetches(access_t a, logic signed [STR_W-1:0] delta,
                                             int degree);
        logic [BLK_W-1:0] cand;
        pf_req_t          r;
        int               n;
        n = 0;
        for (int d = 1; d <= degree; d++)
        begin
            cand = a.block_addr + BLK_W'(delta) * BLK_W'(d);
            if (vpf || (cand >> PGB) == (a.block_addr >> PGB))
            begin
                r.prefetch_block = cand;
                r.fill_here = a.mshr_fill_ok;
                r.meta_out = a.meta_in;
                r.last_request = 1'b0;
                expected_pf.push_back(r);
                n++;
            end
        end
        if (n > 0)
            expected_pf[$].last_request = 1'b1;
    endfunction

    // Advance the shadow state by one access and queue the requests it causes.
    function automatic void predict_prefetches(access_t a);
        int                      base;
        int                      hw;
        int                      w;
        int                      sb;
        bit                      hit;
        logic signed [STR_W-1:0] new_s;
        logic signed [STR_W-1:0] old_s;
        int                      conf;
        logic [CLS_W-1:0]        cls;
        logic [SIG_W-1:0]        sig;
        logic [SIG_W-1:0]        old_sig;
        logic [SIG_W-1:0]        bits;
        base = int'(a.instr_addr % IPS) * IPW;
        hit = 0;
        hw = 0;
        new_s = '0;
        conf = 0;
        cls = CL_NL;
        sig = '0;
        old_sig = '0;
        for (int i = 0; i < IPW; i++)
            if (!hit && ipt_valid[base + i] && ipt_tag[base + i] == a.instr_addr)
            begin
                hit = 1;
                hw = i;
            end
        if (hit)
        begin
            old_s = ipt_str[base + hw];
            new_s = $signed({1'b0, a.block_addr}) - $signed({1'b0, ipt_blk[base + hw]});
            conf = ipt_conf[base + hw];
            old_sig = ipt_sig[base + hw];
            sig = old_sig;
            if (new_s == old_s && new_s != 0)
            begin
                if (conf < 8)
                    conf++;
            end
            else if (new_s != old_s && conf > 0)
                conf--;
            cls = class_of(old_s, new_s, conf, ipt_cls[base + hw]);
            if (new_s != 0)
            begin
                bits = SIG_W'(((new_s < 0) ? -new_s : new_s) & 'hF);
                if (new_s < 0)
                    bits |= 'h10;
                sig = (sig << 3) ^ bits;
            end
        end
        if (new_s > 0)
            up_cnt++;
        else if (new_s < 0)
            down_cnt++;
        if (up_cnt - down_cnt > 3)
            stream_dir = 1;
        else if (down_cnt - up_cnt > 3)
            stream_dir = -1;
        if (up_cnt + down_cnt > 1024)
        begin
            up_cnt >>= 1;
            down_cnt >>= 1;
        end
        w = hit ? hw : ip_victim(base);
        ipt_valid[base + w] = 1;
        ipt_tag[base + w] = a.instr_addr;
        ipt_blk[base + w] = a.block_addr;
        ipt_str[base + w] = new_s;
        ipt_conf[base + w] = conf;
        ipt_cls[base + w] = cls;
        ipt_sig[base + w] = sig;
        touch_ip(base, w);
        case (cls)
            CL_CS:
                if (new_s != 0)
                    queue_prefetches(a, new_s, DEG_CS);
            CL_CPLX:
            begin
                // Train the old signature with the new stride, then look up
                // the updated signature for the delta to follow.
                if (hit && new_s != 0)
                begin
                    sb = int'(old_sig % SGS) * SGW;
                    w = -1;
                    for (int i = 0; i < SGW; i++)
                        if (w < 0 && sgt_valid[sb + i] && sgt_tag[sb + i] == old_sig)
                            w = i;
                    if (w < 0)
                        w = sig_victim(sb);
                    sgt_valid[sb + w] = 1;
                    sgt_tag[sb + w] = old_sig;
                    sgt_delta[sb + w] = new_s;
                    touch_sig(sb, w);
                end
                sb = int'(sig % SGS) * SGW;
                w = -1;
                for (int i = 0; i < SGW; i++)
                    if (w < 0 && sgt_valid[sb + i] && sgt_tag[sb + i] == sig)
                        w = i;
                if (w >= 0)
                begin
                    touch_sig(sb, w);
                    if (sgt_delta[sb + w] != 0)
                        queue_prefetches(a, sgt_delta[sb + w], DEG_CPLX);
                end
            end
            CL_GS:
                if (stream_dir != 0)
                    queue_prefetches(a, STR_W'(stream_dir), DEG_GS);
            default:
                queue_prefetches(a, 1, DEG_NL);
        endcase
    endfunction

    // Driver: presents the queued accesses in order and predicts on accept.
    // While hold_sender is set, each new access waits until every predicted
    // request of the earlier ones has come.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.instr_addr <= '0;
            req.block_addr <= '0;
            req.mshr_fill_ok <= 1'b0;
            req.meta_in <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_prefetches({req.instr_addr, req.block_addr,
                                    req.mshr_fill_ok, req.meta_in});
            if ((!req.valid || req.ready) )
            begin
                if (pending_access.size() > 0 &&
                    !(hold_sender && expected_pf.size() > 0) &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    access_t a;
                    a = pending_access.pop_front();
                    req.valid <= 1'b1;
                    req.instr_addr <= a.instr_addr;
                    req.block_addr <= a.block_addr;
                    req.mshr_fill_ok <= a.mshr_fill_ok;
                    req.meta_in <= a.meta_in;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted request against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pf.ready <= 1'b0;
        else
        begin
            if (pf.valid && pf.ready)
            begin
                pf_req_t got;
                got = {pf.prefetch_block, pf.fill_here, pf.meta_out, pf.last_request};
                if (expected_pf.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected prefetch block %h", got.prefetch_block);
                end
                else
                begin
                    pf_req_t exp_r;
                    exp_r = expected_pf.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp blk %h fill %b meta %h last %b,",
                                      " got blk %h fill %b meta %h last %b"},
                                     exp_r.prefetch_block, exp_r.fill_here,
                                     exp_r.meta_out, exp_r.last_request,
                                     got.prefetch_block, got.fill_here,
                                     got.meta_out, got.last_request);
                    end
                end
            end
            pf.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic access_t rand_access(logic [IP_W-1:0] ip, logic [BLK_W-1:0] blk);
        access_t a;
        a.instr_addr = ip;
        a.block_addr = blk;
        a.mshr_fill_ok = $urandom_range(1);
        a.meta_in = $urandom;
        return a;
    endfunction

    function automatic logic [BLK_W-1:0] rand_block();
        return BLK_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IP_W-1:0] rand_ip();
        return IP_W'({$urandom, $urandom});
    endfunction

    task automatic wait_drained();
        while (pending_access.size() > 0 || req.valid || expected_pf.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vpf(bit v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        vpf = v;
    endtask

    // One random phase: mostly strided, signature-patterned and streaming
    // loads from a small pool of IPs, plus some noise.
    task automatic random_phase(int count);
        logic [IP_W-1:0]  ips[8];
        logic [BLK_W-1:0] cur[8];
        int               strd[8];
        int               k;
        int               pat;
        for (int i = 0; i < 8; i++)
        begin
            ips[i] = rand_ip();
            cur[i] = rand_block();
            strd[i] = $urandom_range(1, 9) * ($urandom_range(1) ? 1 : -1);
        end
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(7);
            pat = $urandom_range(9);
            if (pat < 5)
                cur[k] = cur[k] + BLK_W'(strd[k]);
            else if (pat < 8)
                cur[k] = cur[k] + BLK_W'((n % 3 == 0) ? strd[k] * 3 : strd[k]);
            else if (pat < 9)
                cur[k] = rand_block();
            else
                ips[k] = rand_ip();
            pending_access.push_back(rand_access(ips[k], cur[k]));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        hold_sender = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        sender_idle_pct = 27;
        receiver_idle_pct = 85;
        clear_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, a constant stride that builds
        // confidence, a page-crossing stride, and a wrap at the block width.
        pending_access.push_back('{'0, '0, 1'b0, '0});
        pending_access.push_back('{'1, '1, 1'b1, '1});
        pending_access.push_back('{'1, '0, 1'b0, 32'h5A5A_A5A5});
        for (int i = 0; i < 8; i++)
            pending_access.push_back(rand_access(48'h1234, 58'h100 + 58'(i * 2)));
        for (int i = 0; i < 6; i++)
            pending_access.push_back(rand_access(48'h77, '1 - 58'(i * 3)));
        for (int i = 0; i < 5; i++)
            pending_access.push_back(rand_access(48'h999, 58'h3F + 58'(i * 40)));
        wait_drained();

        // Strided accesses of the same IP with page crossing allowed; the tables keep training.
        write_vpf(1'b1);
        for (int i = 0; i < 6; i++)
            pending_access.push_back(rand_access(48'h1234, 58'h110 + 58'(i * 20)));
        random_phase(50);

        // While this drain runs, the sender holds each access until every
        // predicted request of the earlier ones has come.
        hold_sender = 1'b1;
        wait_drained();
        hold_sender = 1'b0;
        write_vpf(1'b0);
        sender_idle_pct = 85;
        receiver_idle_pct = 27;
        random_phase(42);
        wait_drained();

        write_vpf(1'b1);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_phase(42);
        wait_drained();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
